[design/sorted_priority_queue_macros.svh]
// Assertion macros used by the sorted priority queue top level.
// Each macro samples on clk and is disabled while rst_n is low.
`ifndef SORTED_PRIORITY_QUEUE_MACROS_SVH
`define SORTED_PRIORITY_QUEUE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SPQ_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SPQ_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/spq_pkg.sv]
// Package for the sorted priority queue: operation codes, data width and
// the operation struct broadcast to every cell. No dependencies.
package spq_pkg;

    localparam int DATA_W = 32;

    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_REMOVE = 1'b1;

    typedef logic signed [DATA_W-1:0] data_t;

    // Operation broadcast to the whole row of cells in the same cycle.
    typedef struct packed {
        logic  insert;   // accepted insert on a queue that is not full
        logic  remove;   // accepted remove on a queue that is not empty
        data_t value;    // value being inserted
    } spq_op_t;

endpackage

[design/spq_cell.sv]
// One cell of the sorted queue row: holds one value and trades it with its
// neighbors on insert and remove. Depends on spq_pkg.
module spq_cell
(
    input  logic             clk,
    input  spq_pkg::spq_op_t op,
    input  logic             occupied,   // this slot lies below the entry count
    input  logic             left_gt,    // left neighbor holds a larger value or is free
    input  spq_pkg::data_t   left_value,
    input  spq_pkg::data_t   right_value,
    output logic             gt,
    output spq_pkg::data_t   value
);

    spq_pkg::data_t data_reg;
    spq_pkg::data_t data_next;

    // A free slot counts as larger than anything, so the new value lands
    // after every stored value that is not larger than it.
    assign gt = !occupied || (data_reg > op.value);

    always_comb
    begin
        data_next = data_reg;
        if (op.remove)
        begin
            data_next = right_value;
        end
        else if (op.insert && gt)
        begin
            data_next = left_gt ? left_value : op.value;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign value = data_reg;

endmodule

[design/sorted_priority_queue.sv]
// Sorted priority queue: top level with the row of cells, entry counter and
// output register. Depends on spq_pkg, spq_cell and the assertion macros.
//
// Usage:
// The input channel (s_tvalid, s_tready, s_tuser, s_tdata) carries one
// operation per transaction: s_tuser is the kind (insert or remove) and
// s_tdata the signed value to insert, which a remove ignores. The output
// channel (m_tvalid, m_tready, m_tuser, m_tdata) returns exactly one result
// transaction per operation, in order: m_tuser holds ok and now_empty,
// m_tdata the value taken out by a successful remove, zero otherwise.
// The result is registered: it is written into the output register at the
// accepting edge. Throughput is one operation per cycle while the receiver
// takes results, set by the row of cells, where every cell compares its
// value with the broadcast operand and shifts toward a neighbor in the
// same cycle.
// When the receiver stalls, the result waits in the output register and
// s_tready stays low until it is taken; a result taken in a cycle frees the
// register so a new operation is accepted in that same cycle.
// Reset clears the entry count and the output valid flag, so the queue is
// empty; the cell contents are not reset and are never read while free.
`include "sorted_priority_queue_macros.svh"

module sorted_priority_queue
#(
    parameter int CAPACITY = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [0:0]  s_tuser,   // [0] kind: 0 insert, 1 remove
    input  logic [31:0] s_tdata,   // [31:0] value (signed)
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [1:0]  m_tuser,   // [0] ok, [1] now_empty
    output logic [31:0] m_tdata    // [31:0] removed_value (signed)
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    logic             out_valid_reg;
    logic             out_valid_next;
    logic             ok_reg;
    logic             ok_next;
    logic             empty_reg;
    logic             empty_next;
    spq_pkg::data_t   removed_reg;
    spq_pkg::data_t   removed_next;

    logic             in_fire;
    logic             is_remove;
    logic             full;
    logic             empty;
    spq_pkg::spq_op_t op;

    logic             cell_gt    [CAPACITY];
    spq_pkg::data_t   cell_value [CAPACITY];

    // The output register frees up when its result is taken in this cycle.
    assign s_tready  = !out_valid_reg || m_tready;
    assign in_fire   = s_tvalid && s_tready;
    assign is_remove = (s_tuser[0] == spq_pkg::KIND_REMOVE);

    assign full  = (count_reg == CNT_W'(CAPACITY));
    assign empty = (count_reg == '0);

    // Refused operations leave the row untouched.
    assign op.insert = in_fire && !is_remove && !full;
    assign op.remove = in_fire && is_remove && !empty;
    assign op.value  = s_tdata;

    // Row of cells. Slot i is occupied when i lies below the entry count;
    // the smallest value always sits in cell 0.
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic           left_gt;
        spq_pkg::data_t left_value;
        spq_pkg::data_t right_value;

        if (i == 0)
        begin : g_first
            assign left_gt    = 1'b0;
            assign left_value = cell_value[i];
        end
        else
        begin : g_mid
            assign left_gt    = cell_gt[i-1];
            assign left_value = cell_value[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign right_value = cell_value[i];
        end
        else
        begin : g_inner
            assign right_value = cell_value[i+1];
        end

        spq_cell u_cell
        (
            .clk         (clk),
            .op          (op),
            .occupied    (count_reg > CNT_W'(i)),
            .left_gt     (left_gt),
            .left_value  (left_value),
            .right_value (right_value),
            .gt          (cell_gt[i]),
            .value       (cell_value[i])
        );
    end

    always_comb
    begin
        count_next     = count_reg;
        out_valid_next = out_valid_reg;
        ok_next        = ok_reg;
        empty_next     = empty_reg;
        removed_next   = removed_reg;

        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        if (in_fire)
        begin
            out_valid_next = 1'b1;
            if (is_remove)
            begin
                ok_next      = !empty;
                removed_next = empty ? '0 : cell_value[0];
                // Empty afterwards when at most one entry was held.
                empty_next   = (count_reg <= CNT_W'(1));
                if (!empty)
                begin
                    count_next = count_reg - CNT_W'(1);
                end
            end
            else
            begin
                ok_next      = !full;
                removed_next = '0;
                empty_next   = 1'b0;
                if (!full)
                begin
                    count_next = count_reg + CNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ok_reg      <= ok_next;
        empty_reg   <= empty_next;
        removed_reg <= removed_next;
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tuser[0] = ok_reg;
    assign m_tuser[1] = empty_reg;
    assign m_tdata    = removed_reg;

    `SPQ_ASSERT_NOW(a_count_bound, 1'b1, count_reg <= CNT_W'(CAPACITY), "entry count above capacity")
    `SPQ_ASSERT_NOW(a_empty_flag, m_tvalid, m_tuser[1] == (count_reg == '0), "now_empty disagrees with count")
    `SPQ_ASSERT_NEXT(a_insert_count, op.insert, count_reg == $past(count_reg) + CNT_W'(1), "insert did not grow count")
    `SPQ_ASSERT_NEXT(a_remove_ok, op.remove, m_tvalid && m_tuser[0], "accepted remove not reported done")
    `SPQ_ASSERT_NOW(a_head_sorted, count_reg >= CNT_W'(2), cell_value[0] <= cell_value[1], "head cells out of order")

endmodule

[tb/spq_scoreboard.sv]
// Scoreboard for the sorted priority queue: a mirror of the stored values in
// ascending order that predicts each result, plus the queue of expected results.
// Depends on spq_pkg for the operation codes and the data type.
`timescale 1ns / 1ps

package spq_scoreboard_pkg;

    typedef struct packed {
        logic           ok;
        spq_pkg::data_t removed_value;
        logic           now_empty;
    } queue_result_t;

    class queue_scoreboard;

        int unsigned    depth;
        spq_pkg::data_t held_values[$];       // ascending, smallest at the front
        queue_result_t  expected_results[$];  // oldest at the front
        int unsigned    mismatches;
        int unsigned    inserts;
        int unsigned    removes;
        int unsigned    refused_inserts;
        int unsigned    refused_removes;
        int unsigned    peak_fill;

        function new(int unsigned capacity);
            depth = capacity;
        endfunction

        // Applies one accepted operation to the mirror and queues its result.
        function void note_operation(logic kind, spq_pkg::data_t value);
            queue_result_t want;
            int            pos;
            want = '0;
            if (kind == spq_pkg::KIND_INSERT)
            begin
                if (held_values.size() < int'(depth))
                begin
                    // The new value goes after every smaller value already held.
                    pos = 0;
                    while (pos < held_values.size() && held_values[pos] < value)
                        pos++;
                    held_values.insert(pos, value);
                    want.ok = 1'b1;
                    inserts++;
                    if (held_values.size() > int'(peak_fill))
                        peak_fill = held_values.size();
                end
                else
                begin
                    refused_inserts++;
                end
            end
            else
            begin
                if (held_values.size() > 0)
                begin
                    want.removed_value = held_values.pop_front();
                    want.ok = 1'b1;
                    removes++;
                end
                else
                begin
                    refused_removes++;
                end
            end
            want.now_empty = (held_values.size() == 0);
            expected_results.push_back(want);
        endfunction

        function void record_mismatch(string msg);
            mismatches++;
            if (mismatches <= 10)
                $display("[%0t] MISMATCH: %s", $time, msg);
        endfunction

        // Compares one accepted result with the oldest expectation.
        function void check_result(logic [1:0] flags, logic [31:0] data);
            queue_result_t want;
            if (expected_results.size() == 0)
            begin
                record_mismatch($sformatf("result ok=%0b now_empty=%0b value=%0d with %s",
                                          flags[0], flags[1], $signed(data),
                                          "no operation pending"));
                return;
            end
            want = expected_results.pop_front();
            if (flags[0] !== want.ok)
                record_mismatch($sformatf("ok: expected %0b, got %0b", want.ok, flags[0]));
            if (data !== want.removed_value)
                record_mismatch($sformatf("removed_value: expected %0d, got %0d",
                                          want.removed_value, $signed(data)));
            if (flags[1] !== want.now_empty)
                record_mismatch($sformatf("now_empty: expected %0b, got %0b",
                                          want.now_empty, flags[1]));
        endfunction

        function int unsigned outstanding();
            return expected_results.size();
        endfunction

    endclass

endpackage

[tb/tb.sv]
// Top-level testbench for sorted_priority_queue: drives operations on the input
// stream, takes results from the output stream and checks them against the
// scoreboard. Depends on spq_pkg, spq_scoreboard_pkg and the design sources.
`timescale 1ns / 1ps

module tb;

    localparam int unsigned QUEUE_DEPTH = 16;
    localparam int unsigned RANDOM_OPS  = 500;
    localparam int unsigned IDLE_PCT    = 18;
    localparam int unsigned HOLD_CYCLES = 200;
    localparam int unsigned STALL_LIMIT = 2000;
    localparam int unsigned DIRECTED_OPS = 20;

    localparam spq_pkg::data_t MOST_NEGATIVE = 32'sh8000_0000;
    localparam spq_pkg::data_t MOST_POSITIVE = 32'sh7FFF_FFFF;

    // Values that random inserts fall back on now and then.
    localparam spq_pkg::data_t CORNER_VALUES [5] = '{MOST_NEGATIVE, MOST_POSITIVE, 0, -1, 1};

    // Share of inserts in each block of 40 random operations. The high shares
    // push the queue into the full state, the low ones drain it to empty.
    localparam int unsigned INSERT_BIAS [6] = '{85, 97, 50, 15, 97, 30};

    // Directed opening: a remove on the empty queue, inserts of the extremes and of
    // duplicates, a full drain in sorted order, another refused remove, then two
    // inserts and two removes; each remove carries arbitrary bits that must be ignored.
    localparam logic DIRECTED_KIND [DIRECTED_OPS] = '{
        spq_pkg::KIND_REMOVE,
        spq_pkg::KIND_INSERT, spq_pkg::KIND_INSERT, spq_pkg::KIND_INSERT, spq_pkg::KIND_INSERT,
        spq_pkg::KIND_INSERT, spq_pkg::KIND_INSERT, spq_pkg::KIND_INSERT,
        spq_pkg::KIND_REMOVE, spq_pkg::KIND_REMOVE, spq_pkg::KIND_REMOVE, spq_pkg::KIND_REMOVE,
        spq_pkg::KIND_REMOVE, spq_pkg::KIND_REMOVE, spq_pkg::KIND_REMOVE,
        spq_pkg::KIND_REMOVE,
        spq_pkg::KIND_INSERT, spq_pkg::KIND_INSERT, spq_pkg::KIND_REMOVE, spq_pkg::KIND_REMOVE
    };
    localparam spq_pkg::data_t DIRECTED_VALUE [DIRECTED_OPS] = '{
        32'shFFFF_FFFF,
        0, MOST_NEGATIVE, MOST_POSITIVE, -1,
        1, 0, MOST_POSITIVE,
        0, 32'sh5555_5555, MOST_NEGATIVE, MOST_POSITIVE,
        -1, 32'sh0F0F_0F0F, 32'shAAAA_AAAA,
        32'sh1234_5678,
        32'sh5555_5555, 32'shAAAA_AAAA, 32'shFFFF_FFFF, 0
    };

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [0:0]  s_tuser  = '0;    // [0] kind
    logic [31:0] s_tdata  = '0;    // [31:0] value
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [1:0]  m_tuser;          // [0] ok, [1] now_empty
    logic [31:0] m_tdata;          // [31:0] removed_value

    // Both sides read these at the clock edge; they change only by
    // nonblocking assignment so the edge always sees settled values.
    logic steady_flow   = 1'b0;
    logic receiver_hold = 1'b0;

    int unsigned quiet_cycles = 0;

    event long_stall;

    spq_scoreboard_pkg::queue_scoreboard scoreboard;

    sorted_priority_queue #(
        .CAPACITY (QUEUE_DEPTH)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tuser  (m_tuser),
        .m_tdata  (m_tdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Result side: random back-pressure, none during the steady stretch, and
    // a solid hold-off while a long stall is in progress.
    always @(posedge clk)
    begin
        if (receiver_hold)
            m_tready <= 1'b0;
        else if (steady_flow)
            m_tready <= 1'b1;
        else
            m_tready <= ($urandom_range(99) >= IDLE_PCT);
    end

    // The long stall counts its own cycles. With the output register full,
    // the queue has to drop s_tready while the sender keeps offering.
    initial
    begin
        forever
        begin
            @(long_stall);
            receiver_hold <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clk);
            receiver_hold <= 1'b0;
        end
    end

    // Monitor: the result taken at an edge belongs to an earlier operation,
    // so it is checked before the operation accepted at the same edge is noted.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
                scoreboard.check_result(m_tuser, m_tdata);
            if (s_tvalid && s_tready)
                scoreboard.note_operation(s_tuser[0], spq_pkg::data_t'(s_tdata));
        end
    end

    // Watchdog: counts cycles in which neither stream moves a transaction.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("Watchdog: no transaction for %0d cycles", quiet_cycles);
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    // Offers one operation, possibly after idling at random, and returns at
    // the edge where it is accepted. The valid stays high for a follow-on.
    task automatic send_op(input logic kind, input spq_pkg::data_t value);
        while (!steady_flow && $urandom_range(99) < IDLE_PCT)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid   <= 1'b1;
        s_tuser[0] <= kind;
        s_tdata    <= value;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    initial
    begin
        int unsigned    insert_pct;
        spq_pkg::data_t value;

        scoreboard = new(QUEUE_DEPTH);

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < DIRECTED_OPS; i++)
            send_op(DIRECTED_KIND[i], DIRECTED_VALUE[i]);

        for (int n = 0; n < RANDOM_OPS; n++)
        begin
            insert_pct = INSERT_BIAS[(n / 40) % 6];

            if (n == 150)
                -> long_stall;

            // Let the queue go quiet: every result must come back first.
            if (n == 300)
            begin
                s_tvalid <= 1'b0;
                do
                    @(posedge clk);
                while (scoreboard.outstanding() != 0);
            end

            steady_flow <= (n >= 350 && n < 450);

            if ($urandom_range(99) < insert_pct)
            begin
                // Small values make duplicates common; full-range values
                // exercise every bit of the comparison.
                case ($urandom_range(9))
                    0:       value = CORNER_VALUES[$urandom_range(4)];
                    1, 2, 3: value = spq_pkg::data_t'($urandom_range(16)) - 8;
                    default: value = spq_pkg::data_t'($urandom);
                endcase
                send_op(spq_pkg::KIND_INSERT, value);
            end
            else
            begin
                send_op(spq_pkg::KIND_REMOVE, spq_pkg::data_t'($urandom));
            end
        end

        // The last operation is noted by the monitor at the edge where it was
        // accepted, so let a clock edge pass before looking at the pending count.
        s_tvalid    <= 1'b0;
        steady_flow <= 1'b0;
        do
            @(posedge clk);
        while (scoreboard.outstanding() != 0);
        repeat (4) @(posedge clk);

        $display("Run covered %0d inserts (%0d refused on a full queue) and %0d removes",
                 scoreboard.inserts, scoreboard.refused_inserts, scoreboard.removes);
        $display("(%0d refused on an empty queue); the queue peaked at %0d of %0d entries.",
                 scoreboard.refused_removes, scoreboard.peak_fill, QUEUE_DEPTH);

        if (scoreboard.mismatches == 0 && scoreboard.outstanding() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
